/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. All checks use clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SPE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define SPE_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* rtl/spe_pkg.sv */
package spe_pkg;

  localparam int DEFAULT_MAX_VERTICES = 64;
  localparam int DEFAULT_MAX_DEGREE   = 16;
  localparam int WEIGHT_BITS          = 16;
  localparam int DIST_BITS            = 24;
  localparam int NODE_BITS            = 6;
  localparam int VCOUNT_BITS          = 7;
  localparam int APB_ADDR_BITS        = 3;
  localparam int APB_DATA_BITS        = 32;
  localparam int RESULT_LIMIT         = 64;

  localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 7'd64;

  // Register indexes.
  localparam logic REG_VCOUNT = 1'b0;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

endpackage

/* rtl/spe_cfg.sv */
module spe_cfg
  import spe_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [VCOUNT_BITS-1:0]   vcount_o
);

  logic [VCOUNT_BITS-1:0] vcount_q;
  logic                   sel_vcount;

  // Word index is address bit 2; the low byte bits are ignored.
  assign sel_vcount = (paddr[2] == REG_VCOUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RESET;
    end else if (psel && penable && pwrite && sel_vcount) begin
      vcount_q <= pwdata[VCOUNT_BITS-1:0];
    end
  end

  assign prdata   = sel_vcount ? APB_DATA_BITS'(vcount_q) : '0;
  assign pready   = 1'b1;
  assign vcount_o = vcount_q;

endmodule

/* rtl/shortest_path_engine.sv */
// Shortest path engine: holds an undirected weighted graph as per-vertex adjacency lists
// and runs single-source shortest paths over it. A run from a source, for every reachable
// vertex, searches the n active vertices for the nearest unsettled one and then relaxes
// each edge of its list; one last search then finds none, and every vertex is reported.
// The run time is set by the single read port of the distance memory, which the minimum
// search walks one vertex per cycle, and by the read-modify-write of one edge at a time.
// Each add or clear answers with one word; a run answers with one word per vertex, last
// set on the final one; a bad source or a dropped edge gives a word with error set.
module shortest_path_engine
  import spe_pkg::*;
#(
  parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES,
  parameter int MAX_DEGREE   = DEFAULT_MAX_DEGREE
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               cmd_i,
  input  logic [NODE_BITS-1:0]     node_a_i,
  input  logic [NODE_BITS-1:0]     node_b_i,
  input  logic [WEIGHT_BITS-1:0]   weight_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [NODE_BITS-1:0]     vertex_o,
  output logic [DIST_BITS-1:0]     distance_o,
  output logic                     reachable_o,
  output logic                     error_o,
  output logic                     last_o
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int AW    = $clog2(MAX_VERTICES * MAX_DEGREE);
  localparam int DW    = $clog2(MAX_DEGREE + 1);
  localparam int CW    = (VW > VCOUNT_BITS) ? VW : VCOUNT_BITS;
  localparam int CAP   = (MAX_VERTICES < RESULT_LIMIT) ? MAX_VERTICES : RESULT_LIMIT;
  localparam int ADJ_W = VW + WEIGHT_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD1, S_ADD2, S_ADD3, S_EMIT, S_SCAN, S_SCAN_END, S_PICK,
    S_DEG, S_EDGE, S_ADJ, S_REL, S_OUT, S_OUTW
  } state_e;

  // Configuration register.
  logic [VCOUNT_BITS-1:0] vcount;
  logic [CW-1:0]          act_n;

  spe_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .vcount_o (vcount)
  );

  assign act_n = (CW'(vcount) > CW'(CAP)) ? CW'(CAP) : CW'(vcount);

  // Memories and their read data.
  logic [ADJ_W-1:0]     adj_mem [MAX_VERTICES*MAX_DEGREE];
  logic [DW-1:0]        deg_mem [MAX_VERTICES];
  logic [DIST_BITS-1:0] dist_mem [MAX_VERTICES];

  logic                 adj_we, deg_we, dist_we;
  logic [AW-1:0]        adj_waddr, adj_raddr;
  logic [ADJ_W-1:0]     adj_wdata, adj_rdata_q;
  logic [VW-1:0]        deg_waddr, deg_raddr;
  logic [DW-1:0]        deg_wdata, deg_rdata_q;
  logic                 deg_rvld_q;
  logic [VW-1:0]        dist_waddr, dist_raddr;
  logic [DIST_BITS-1:0] dist_wdata, dist_rdata_q;

  // Control and datapath registers.
  state_e               state_q;
  logic [VW-1:0]        a_q, b_q, best_idx_q, cmp_idx_q, scan_q, out_idx_q, v_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic [DW-1:0]        deg_a_q, deg_b_q, deg_u_q, edge_q;
  logic [DIST_BITS-1:0] best_d_q;
  logic                 found_q, cmp_vld_q, err_q;
  logic [MAX_VERTICES-1:0] deg_vld_q, dvld_q, settled_q;
  logic                 out_vld_q;
  logic [NODE_BITS-1:0] out_vertex_q;
  logic [DIST_BITS-1:0] out_dist_q;
  logic                 out_reach_q, out_err_q, out_last_q;

  logic                 accept, out_free, out_load, add_bad, cand, relax;
  logic [DW-1:0]        deg_rd;
  logic [DW:0]          deg_a_two;
  logic [VW-1:0]        adj_nb;
  logic [WEIGHT_BITS-1:0] adj_w;
  logic [DIST_BITS:0]   sum;
  logic [DIST_BITS-1:0] sum_sat;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_vld_q || out_ready_i;
  assign out_load   = out_free && (state_q == S_EMIT || state_q == S_OUTW);
  assign deg_rd     = deg_rvld_q ? deg_rdata_q : '0;
  assign deg_a_two  = (DW+1)'(deg_a_q) + (DW+1)'(2);
  assign adj_nb     = adj_rdata_q[ADJ_W-1:WEIGHT_BITS];
  assign adj_w      = adj_rdata_q[WEIGHT_BITS-1:0];

  // A self-loop needs two free slots; any other edge needs one in each list.
  assign add_bad = (a_q == b_q) ? (deg_a_two > (DW+1)'(MAX_DEGREE))
                 : ((deg_a_q >= DW'(MAX_DEGREE)) || (deg_rd >= DW'(MAX_DEGREE)));

  // Relaxation sum, saturated at the distance field's maximum.
  assign sum     = {1'b0, best_d_q} + (DIST_BITS+1)'(w_q);
  assign sum_sat = sum[DIST_BITS] ? '1 : sum[DIST_BITS-1:0];
  assign relax   = !dvld_q[v_q] || (sum_sat < dist_rdata_q);

  // Candidate test of the minimum search on the word just read.
  assign cand = cmp_vld_q && dvld_q[cmp_idx_q] && !settled_q[cmp_idx_q] &&
                (!found_q || (dist_rdata_q < best_d_q));

  // Memory addresses and writes per state.
  always_comb begin
    adj_we     = 1'b0;
    adj_waddr  = AW'(a_q) * AW'(MAX_DEGREE) + AW'(deg_a_q);
    adj_wdata  = {b_q, w_q};
    adj_raddr  = AW'(best_idx_q) * AW'(MAX_DEGREE) + AW'(edge_q);
    deg_we     = 1'b0;
    deg_waddr  = a_q;
    deg_wdata  = deg_a_q + DW'(1);
    deg_raddr  = a_q;
    dist_we    = 1'b0;
    dist_waddr = v_q;
    dist_wdata = sum_sat;
    dist_raddr = scan_q;
    unique case (state_q)
      S_IDLE: begin
        deg_raddr  = VW'(node_a_i);
        dist_waddr = VW'(node_a_i);
        dist_wdata = '0;
        dist_we    = accept && (cmd_e'(cmd_i) == CMD_RUN) &&
                     (CW'(node_a_i) < act_n);
      end
      S_ADD1: begin
        deg_raddr = b_q;
      end
      S_ADD2: begin
        adj_we = !add_bad;
        deg_we = !add_bad;
        if (a_q == b_q) begin
          deg_wdata = deg_a_two[DW-1:0];
        end
      end
      S_ADD3: begin
        adj_we = 1'b1;
        adj_wdata = {a_q, w_q};
        if (a_q == b_q) begin
          adj_waddr = AW'(a_q) * AW'(MAX_DEGREE) + AW'(deg_a_q) + AW'(1);
        end else begin
          adj_waddr = AW'(b_q) * AW'(MAX_DEGREE) + AW'(deg_b_q);
          deg_we    = 1'b1;
          deg_waddr = b_q;
          deg_wdata = deg_b_q + DW'(1);
        end
      end
      S_PICK: begin
        deg_raddr = best_idx_q;
      end
      S_ADJ: begin
        dist_raddr = adj_nb;
      end
      S_REL: begin
        dist_we = relax;
      end
      S_OUT, S_OUTW: begin
        dist_raddr = out_idx_q;
      end
      default: begin
      end
    endcase
  end

  // Synchronous memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    adj_rdata_q  <= adj_mem[adj_raddr];
    deg_rdata_q  <= deg_mem[deg_raddr];
    deg_rvld_q   <= deg_vld_q[deg_raddr];
    dist_rdata_q <= dist_mem[dist_raddr];
  end

  // Sequencer and output word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      deg_vld_q <= '0;
      dvld_q    <= '0;
      settled_q <= '0;
      found_q   <= 1'b0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && out_ready_i && !out_load) begin
        out_vld_q <= 1'b0;
      end
      if (deg_we) begin
        deg_vld_q[deg_waddr] <= 1'b1;
      end
      if (dist_we && state_q == S_REL) begin
        dvld_q[v_q] <= 1'b1;
      end
      cmp_vld_q <= (state_q == S_SCAN);
      cmp_idx_q <= scan_q;
      if (cand) begin
        found_q    <= 1'b1;
        best_idx_q <= cmp_idx_q;
        best_d_q   <= dist_rdata_q;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            a_q <= VW'(node_a_i);
            b_q <= VW'(node_b_i);
            w_q <= weight_i;
            unique case (cmd_e'(cmd_i))
              CMD_ADD: begin
                if (CW'(node_a_i) >= act_n || CW'(node_b_i) >= act_n) begin
                  err_q   <= 1'b1;
                  state_q <= S_EMIT;
                end else begin
                  err_q   <= 1'b0;
                  state_q <= S_ADD1;
                end
              end
              CMD_RUN: begin
                if (CW'(node_a_i) >= act_n) begin
                  err_q   <= 1'b1;
                  state_q <= S_EMIT;
                end else begin
                  err_q     <= 1'b0;
                  settled_q <= '0;
                  dvld_q    <= MAX_VERTICES'(1) << VW'(node_a_i);
                  found_q   <= 1'b0;
                  scan_q    <= '0;
                  state_q   <= S_SCAN;
                end
              end
              CMD_CLEAR: begin
                err_q     <= 1'b0;
                deg_vld_q <= '0;
                state_q   <= S_EMIT;
              end
              CMD_NONE: begin
                state_q <= S_IDLE;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_ADD1: begin
          deg_a_q <= deg_rd;
          state_q <= S_ADD2;
        end
        S_ADD2: begin
          deg_b_q <= deg_rd;
          if (add_bad) begin
            err_q   <= 1'b1;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_ADD3;
          end
        end
        S_ADD3: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_vld_q    <= 1'b1;
            out_vertex_q <= '0;
            out_dist_q   <= '0;
            out_reach_q  <= 1'b0;
            out_err_q    <= err_q;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (CW'(scan_q) == act_n - CW'(1)) begin
            state_q <= S_SCAN_END;
          end else begin
            scan_q <= scan_q + VW'(1);
          end
        end
        S_SCAN_END: begin
          state_q <= S_PICK;
        end
        S_PICK: begin
          if (!found_q) begin
            out_idx_q <= '0;
            state_q   <= S_OUT;
          end else begin
            settled_q[best_idx_q] <= 1'b1;
            state_q <= S_DEG;
          end
        end
        S_DEG: begin
          deg_u_q <= deg_rd;
          edge_q  <= '0;
          state_q <= S_EDGE;
        end
        S_EDGE: begin
          if (edge_q == deg_u_q) begin
            found_q <= 1'b0;
            scan_q  <= '0;
            state_q <= S_SCAN;
          end else begin
            state_q <= S_ADJ;
          end
        end
        S_ADJ: begin
          v_q <= adj_nb;
          w_q <= adj_w;
          if (CW'(adj_nb) >= act_n) begin
            edge_q  <= edge_q + DW'(1);
            state_q <= S_EDGE;
          end else begin
            state_q <= S_REL;
          end
        end
        S_REL: begin
          edge_q  <= edge_q + DW'(1);
          state_q <= S_EDGE;
        end
        S_OUT: begin
          state_q <= S_OUTW;
        end
        S_OUTW: begin
          if (out_free) begin
            out_vld_q    <= 1'b1;
            out_vertex_q <= NODE_BITS'(out_idx_q);
            out_dist_q   <= dvld_q[out_idx_q] ? dist_rdata_q : '0;
            out_reach_q  <= dvld_q[out_idx_q];
            out_err_q    <= 1'b0;
            out_last_q   <= (CW'(out_idx_q) == act_n - CW'(1));
            if (CW'(out_idx_q) == act_n - CW'(1)) begin
              state_q <= S_IDLE;
            end else begin
              out_idx_q <= out_idx_q + VW'(1);
              state_q   <= S_OUT;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign vertex_o    = out_vertex_q;
  assign distance_o  = out_dist_q;
  assign reachable_o = out_reach_q;
  assign error_o     = out_err_q;
  assign last_o      = out_last_q;

  // Checks on the engine's own bookkeeping.
`include "assert_macros.svh"
  `SPE_NEVER(a_settled_valid, |(settled_q & ~dvld_q), "settled vertex without distance")
  `SPE_ASSERT(a_err_last, out_vld_q && out_err_q |-> out_last_q && !out_reach_q, "error word not final")
  `SPE_ASSERT(a_busy_no_ready, state_q != S_IDLE |-> !in_ready_o, "input taken while busy")

endmodule

/* dv/shortest_path_engine_test.sv */
module shortest_path_engine_test;
  import spe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NODE_BITS-1:0] vertex;
    logic [DIST_BITS-1:0] distance;
    logic                 reachable;
    logic                 error;
    logic                 last;
  } path_word_t;

  // Mirrors the graph and predicts the words that every accepted command
  // word produces, then matches them in order against the output channel.
  class path_scoreboard;
    logic [NODE_BITS-1:0]   adj_node [64][16];
    logic [WEIGHT_BITS-1:0] adj_weight [64][16];
    int unsigned            degree [64];
    int unsigned            vcount;
    path_word_t             pending [$];
    int unsigned            failures;
    int unsigned            adds_ok, adds_dropped, runs_ok, runs_bad, clears, words_seen;

    function new();
      vcount = VCOUNT_RESET;
      foreach (degree[i]) degree[i] = 0;
      failures = 0;
      adds_ok = 0;
      adds_dropped = 0;
      runs_ok = 0;
      runs_bad = 0;
      clears = 0;
      words_seen = 0;
    endfunction

    function int unsigned live_count();
      return (vcount > 64) ? 64 : vcount;
    endfunction

    function void push_word(int unsigned v, logic [DIST_BITS-1:0] d, bit r, bit e, bit l);
      path_word_t w;
      w.vertex = NODE_BITS'(v);
      w.distance = d;
      w.reachable = r;
      w.error = e;
      w.last = l;
      pending = {pending, w};
    endfunction

    function void link(int unsigned from, int unsigned to, logic [WEIGHT_BITS-1:0] wt);
      adj_node[from][degree[from]] = NODE_BITS'(to);
      adj_weight[from][degree[from]] = wt;
      degree[from]++;
    endfunction

    // Dijkstra over the mirrored lists, lowest index wins ties.
    function void solve_paths(int unsigned src);
      int unsigned n;
      logic [DIST_BITS:0] path_len [64];
      bit known [64];
      bit done [64];
      bit found;
      int unsigned u, v;
      logic [DIST_BITS:0] sum;
      n = live_count();
      if (src >= n) begin
        runs_bad++;
        push_word(0, 0, 0, 1, 1);
        return;
      end
      runs_ok++;
      for (int i = 0; i < 64; i++) begin
        path_len[i] = 0;
        known[i] = 0;
        done[i] = 0;
      end
      known[src] = 1;
      for (int k = 0; k < n; k++) begin
        found = 0;
        u = 0;
        for (int i = 0; i < n; i++) begin
          if (known[i] && !done[i] && (!found || path_len[i] < path_len[u])) begin
            u = i;
            found = 1;
          end
        end
        if (!found) break;
        done[u] = 1;
        for (int j = 0; j < degree[u]; j++) begin
          v = adj_node[u][j];
          if (v < n) begin
            sum = path_len[u] + adj_weight[u][j];
            if (sum > {1'b0, {DIST_BITS{1'b1}}}) sum = {1'b0, {DIST_BITS{1'b1}}};
            if (!known[v] || sum < path_len[v]) begin
              path_len[v] = sum;
              known[v] = 1;
            end
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        push_word(i, known[i] ? path_len[i][DIST_BITS-1:0] : '0, known[i], 0, i + 1 == n);
      end
    endfunction

    function void note_command(cmd_e cmd, int unsigned a, int unsigned b,
                               logic [WEIGHT_BITS-1:0] wt);
      int unsigned n;
      bit bad;
      n = live_count();
      case (cmd)
        CMD_ADD: begin
          bad = 0;
          if (a >= n || b >= n) bad = 1;
          else if (a == b) bad = degree[a] + 2 > 16;
          else bad = degree[a] >= 16 || degree[b] >= 16;
          if (!bad) begin
            link(a, b, wt);
            link(b, a, wt);
            adds_ok++;
          end else begin
            adds_dropped++;
          end
          push_word(0, 0, 0, bad, 1);
        end
        CMD_RUN: solve_paths(a);
        CMD_CLEAR: begin
          foreach (degree[i]) degree[i] = 0;
          clears++;
          push_word(0, 0, 0, 0, 1);
        end
        default: ;
      endcase
    endfunction

    function void check_word(path_word_t got);
      path_word_t want;
      words_seen++;
      if (pending.size() == 0) begin
        $error("unexpected output word: vertex %0d distance %0d", got.vertex, got.distance);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (got.vertex !== want.vertex) begin
        $error("vertex: expected %0d, got %0d", want.vertex, got.vertex);
        failures++;
      end
      if (got.distance !== want.distance) begin
        $error("distance: expected %0d, got %0d", want.distance, got.distance);
        failures++;
      end
      if (got.reachable !== want.reachable) begin
        $error("reachable: expected %0b, got %0b", want.reachable, got.reachable);
        failures++;
      end
      if (got.error !== want.error) begin
        $error("error: expected %0b, got %0b", want.error, got.error);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [1:0]               cmd_i;
  logic [NODE_BITS-1:0]     node_a_i;
  logic [NODE_BITS-1:0]     node_b_i;
  logic [WEIGHT_BITS-1:0]   weight_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [NODE_BITS-1:0]     vertex_o;
  logic [DIST_BITS-1:0]     distance_o;
  logic                     reachable_o;
  logic                     error_o;
  logic                     last_o;

  path_scoreboard board;
  bit             steady;

  shortest_path_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .node_a_i    (node_a_i),
    .node_b_i    (node_b_i),
    .weight_i    (weight_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .vertex_o    (vertex_o),
    .distance_o  (distance_o),
    .reachable_o (reachable_o),
    .error_o     (error_o),
    .last_o      (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Output side: check each accepted word and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_word('{vertex_o, distance_o, reachable_o, error_o, last_o});
      end
      out_ready_i <= steady || ($urandom_range(99) >= 31);
    end
  end

  // Register write through the setup and access phases.
  task automatic write_vcount(int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_BITS'(4 * REG_VCOUNT);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.vcount = value & 7'h7f;
  endtask

  // Present one command word and hold it until the engine takes it.
  task automatic send_command(cmd_e cmd, int unsigned a, int unsigned b, int unsigned wt);
    if (!steady && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    node_a_i <= NODE_BITS'(a);
    node_b_i <= NODE_BITS'(b);
    weight_i <= WEIGHT_BITS'(wt);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_command(cmd, a & 32'h3f, b & 32'h3f, WEIGHT_BITS'(wt));
  endtask

  // Wait until every predicted word has come back, then let the engine settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Mostly well-formed traffic within the vertex range, with some noise.
  task automatic random_traffic(int unsigned count_items);
    int unsigned n;
    int unsigned pick;
    int unsigned sent;
    n = board.live_count();
    sent = 0;
    while (sent < count_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_command(CMD_ADD, $urandom_range(n - 1), $urandom_range(n - 1),
                     ($urandom_range(3) == 0) ? $urandom : $urandom_range(40));
      end else if (pick < 75) begin
        send_command(CMD_RUN, $urandom_range(n - 1), $urandom, $urandom);
      end else if (pick < 80) begin
        send_command(CMD_CLEAR, $urandom, $urandom, $urandom);
      end else if (pick < 88) begin
        send_command(CMD_ADD, $urandom, $urandom, $urandom);
      end else if (pick < 95) begin
        send_command(CMD_RUN, $urandom, $urandom, $urandom);
      end else begin
        send_command(CMD_NONE, $urandom, $urandom, $urandom);
        sent--;
      end
      sent++;
    end
  endtask

  initial begin
    board = new();
    steady = 1'b0;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    cmd_i = CMD_ADD;
    node_a_i = '0;
    node_b_i = '0;
    weight_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes, every command, self-loop and ignored command at full size.
    send_command(CMD_ADD, 0, 1, 0);
    send_command(CMD_ADD, 62, 63, 16'hffff);
    send_command(CMD_ADD, 1, 2, 7);
    send_command(CMD_ADD, 5, 5, 3);
    send_command(CMD_ADD, 6'h2a, 6'h15, 16'haaaa);
    send_command(CMD_ADD, 6'h15, 6'h3f, 16'h5555);
    send_command(CMD_RUN, 0, 6'h3f, 16'hffff);
    send_command(CMD_RUN, 63, 0, 0);
    send_command(CMD_NONE, 6'h3f, 6'h3f, 16'hffff);
    send_command(CMD_CLEAR, 0, 0, 0);
    send_command(CMD_RUN, 5, 0, 0);
    drain_results();

    // With no vertices in use every add and run is rejected.
    write_vcount(0);
    send_command(CMD_ADD, 0, 0, 1);
    send_command(CMD_RUN, 0, 0, 0);
    drain_results();

    // A single vertex: self-loops fill its list until one is dropped.
    write_vcount(1);
    for (int i = 0; i < 9; i++) send_command(CMD_ADD, 0, 0, i);
    send_command(CMD_ADD, 0, 1, 4);
    send_command(CMD_RUN, 0, 0, 0);
    send_command(CMD_RUN, 1, 0, 0);
    drain_results();

    // Register value above the array size is clipped to 64 vertices.
    write_vcount(127);
    send_command(CMD_CLEAR, 0, 0, 0);
    send_command(CMD_ADD, 63, 10, 9);
    send_command(CMD_RUN, 10, 0, 0);
    drain_results();

    // Small graphs so that lists fill up and runs stay short.
    write_vcount(6);
    random_traffic(30);
    drain_results();
    write_vcount(10);
    random_traffic(20);
    // Hold off until the engine has answered everything, then run without gaps.
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    steady = 1'b1;
    random_traffic(25);
    steady = 1'b0;
    drain_results();

    // Back to the full vertex range for a last few words.
    write_vcount(64);
    random_traffic(8);
    drain_results();

    $display("Covered %0d good adds, %0d dropped adds, %0d runs, %0d bad runs, %0d clears.",
             board.adds_ok, board.adds_dropped, board.runs_ok, board.runs_bad, board.clears);
    $display("Checked %0d output words over vertex counts 0, 1, 6, 10, 64 and 127.",
             board.words_seen);
    if (board.failures == 0 && board.pending.size() == 0) begin
      $display("shortest_path_engine verification clean");
    end else begin
      $display("shortest_path_engine verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("shortest_path_engine verification failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/spe_pkg.sv
rtl/spe_cfg.sv
rtl/shortest_path_engine.sv
dv/shortest_path_engine_test.sv
